// ----- design/bfcr_pkg.sv -----
// Shared types and constants for the bit field copy realigner.
package bfcr_pkg;

    localparam int ByteW         = 8;
    localparam int OffsetW       = 3;
    localparam int LenFieldW     = 16;
    localparam int LengthWidthDef = 16;
    localparam int QueueDepthDef = 4;
    localparam int InDataW       = 32;
    localparam int OutDataW      = 16;

    // input kind carried on tuser
    localparam logic ActStart = 1'b0;
    localparam logic ActData  = 1'b1;

    // one queue slot: the first result word always exists, a second one is optional
    // and is always the final word of the transfer
    typedef struct packed {
        logic [ByteW-1:0] hi_byte;
        logic [ByteW-1:0] hi_mask;
        logic             hi_last;
        logic             lo_valid;
        logic [ByteW-1:0] lo_byte;
        logic [ByteW-1:0] lo_mask;
    } t_slot;

endpackage

// ----- design/bit_field_copy_realigner.sv -----
// Top level of the MSB-first bit field copy realigner.
// Copies a run of bits from a source byte stream into destination bytes,
// bit 0 being the MSB. A start word (tuser = 0) loads source offset, destination
// offset and bit length; each data word (tuser = 1) supplies the next source byte.
// Output words carry the destination byte and a write mask for a read-modify-write
// merge; tlast marks the final byte, and a zero length run gives nothing. The
// input side takes one word per cycle while the queue is not full. A front end
// builds destination bytes and pushes them into a 4-slot queue; the back end
// emits one output word per cycle while the queue holds slots and the output is
// not stalled, so a data word that completes two bytes (only at the end of a run)
// gives two output words, registered in the queue and then in the output register.
module bit_field_copy_realigner #(
    parameter int LENGTH_WIDTH = bfcr_pkg::LengthWidthDef,
    parameter int QUEUE_DEPTH  = bfcr_pkg::QueueDepthDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // src_offset[2:0], dst_offset[5:3], bit_length[21:6], data_byte[29:22], zero fill
    input  logic [bfcr_pkg::InDataW-1:0]   s_axis_tdata,
    // action[0]
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_byte[7:0], out_mask[15:8]
    output logic [bfcr_pkg::OutDataW-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast
);
    import bfcr_pkg::*;

    t_slot            push_slot, head;
    logic             push, pop, empty, full;
    logic [ByteW-1:0] out_byte, out_mask;

    bfcr_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tuser[0]),
        .i_src_offset (s_axis_tdata[2:0]),
        .i_dst_offset (s_axis_tdata[5:3]),
        .i_bit_length (s_axis_tdata[21:6]),
        .i_data_byte  (s_axis_tdata[29:22]),
        .i_full       (full),
        .o_push       (push),
        .o_slot       (push_slot)
    );

    bfcr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_slot  (push_slot),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    bfcr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (out_byte),
        .o_mask  (out_mask),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_mask, out_byte};

endmodule

// ----- design/bfcr_front.sv -----
// Front end: accepts start and data words, merges source bits into destination bytes.
module bfcr_front #(
    parameter int LENGTH_WIDTH = bfcr_pkg::LengthWidthDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [bfcr_pkg::OffsetW-1:0]  i_src_offset,
    input  logic [bfcr_pkg::OffsetW-1:0]  i_dst_offset,
    input  logic [bfcr_pkg::LenFieldW-1:0] i_bit_length,
    input  logic [bfcr_pkg::ByteW-1:0]    i_data_byte,
    input  logic                          i_full,
    output logic                          o_push,
    output bfcr_pkg::t_slot               o_slot
);
    import bfcr_pkg::*;

    logic [ByteW-1:0]        r_pend_bits, n_pend_bits;
    logic [ByteW-1:0]        r_pend_mask, n_pend_mask;
    logic [OffsetW-1:0]      r_pos, n_pos;
    logic [LENGTH_WIDTH-1:0] r_left, n_left;
    logic [OffsetW-1:0]      r_skip, n_skip;
    logic                    r_first, n_first;

    logic                    accept;
    logic [OffsetW-1:0]      skip;
    logic [3:0]              avail;
    logic [3:0]              take;
    logic [LENGTH_WIDTH-1:0] rem;
    logic [ByteW-1:0]        take_mask;
    logic [ByteW-1:0]        aligned;
    logic [2*ByteW-1:0]      win_bits;
    logic [2*ByteW-1:0]      win_mask;
    logic [3:0]              total;
    logic                    full_byte;
    logic                    done;
    logic [ByteW-1:0]        hi_bits, hi_mask;
    logic [31:0]             len_ext;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        skip      = r_first ? r_skip : '0;
        avail     = 4'(ByteW) - {1'b0, skip};
        if (r_left < LENGTH_WIDTH'(avail)) begin
            take = r_left[3:0];
        end else begin
            take = avail;
        end
        rem       = r_left - LENGTH_WIDTH'(take);
        take_mask = ~(8'hff >> take);
        aligned   = (i_data_byte << skip) & take_mask;
        win_bits  = {aligned, 8'h00} >> r_pos;
        win_mask  = {take_mask, 8'h00} >> r_pos;
        total     = {1'b0, r_pos} + take;
        full_byte = total[3];
        done      = (rem == '0);
        hi_bits   = r_pend_bits | win_bits[15:8];
        hi_mask   = r_pend_mask | win_mask[15:8];
        len_ext   = 32'(i_bit_length);
    end

    always_comb begin
        n_pend_bits = r_pend_bits;
        n_pend_mask = r_pend_mask;
        n_pos       = r_pos;
        n_left      = r_left;
        n_skip      = r_skip;
        n_first     = r_first;
        o_push      = 1'b0;

        o_slot.hi_byte  = hi_bits;
        o_slot.hi_mask  = hi_mask;
        o_slot.hi_last  = done && (!full_byte || total[2:0] == '0);
        o_slot.lo_valid = full_byte && done && (win_mask[7:0] != '0);
        o_slot.lo_byte  = win_bits[7:0];
        o_slot.lo_mask  = win_mask[7:0];

        if (accept) begin
            if (i_action == ActStart) begin
                n_skip      = i_src_offset;
                n_pos       = i_dst_offset;
                n_left      = len_ext[LENGTH_WIDTH-1:0];
                n_pend_bits = '0;
                n_pend_mask = '0;
                n_first     = 1'b1;
            end else if (r_left != '0) begin
                n_first = 1'b0;
                n_left  = rem;
                n_pos   = total[2:0];
                o_push  = full_byte || done;
                if (full_byte) begin
                    n_pend_bits = win_bits[7:0];
                    n_pend_mask = win_mask[7:0];
                end else begin
                    n_pend_bits = hi_bits;
                    n_pend_mask = hi_mask;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_mask <= '0;
            r_pos       <= '0;
            r_left      <= '0;
            r_skip      <= '0;
            r_first     <= 1'b0;
        end else begin
            r_pend_bits <= n_pend_bits;
            r_pend_mask <= n_pend_mask;
            r_pos       <= n_pos;
            r_left      <= n_left;
            r_skip      <= n_skip;
            r_first     <= n_first;
        end
    end

endmodule

// ----- design/bfcr_queue.sv -----
// Small FIFO of result slots between the front and back ends.
module bfcr_queue #(
    parameter int DEPTH = bfcr_pkg::QueueDepthDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bfcr_pkg::t_slot i_slot,
    input  logic            i_pop,
    output bfcr_pkg::t_slot o_head,
    output logic            o_empty,
    output logic            o_full
);
    import bfcr_pkg::*;

    localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_slot           r_mem [DEPTH];
    logic [IdxW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == IdxW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == IdxW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- design/bfcr_back.sv -----
// Back end: unpacks queue slots into one or two output words with an output register.
module bfcr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfcr_pkg::t_slot             i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bfcr_pkg::ByteW-1:0]  o_byte,
    output logic [bfcr_pkg::ByteW-1:0]  o_mask,
    output logic                        o_last
);
    import bfcr_pkg::*;

    logic             r_valid;
    logic             r_phase;
    logic [ByteW-1:0] r_byte, r_mask;
    logic             r_last;
    logic             load;

    assign load    = !i_empty && (!r_valid || i_ready);
    assign o_pop   = load && (r_phase || !i_head.lo_valid);
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_mask  = r_mask;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !r_phase && i_head.lo_valid;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload: second word of a slot is always the final one
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_phase) begin
                r_byte <= i_head.lo_byte;
                r_mask <= i_head.lo_mask;
                r_last <= 1'b1;
            end else begin
                r_byte <= i_head.hi_byte;
                r_mask <= i_head.hi_mask;
                r_last <= i_head.hi_last;
            end
        end
    end

endmodule

// ----- design/bfcr_checker.sv -----
// Port-level checks on the realigner output stream, bound to the top level.
module bfcr_props (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // every word writes something
    a_mask_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:8] != 8'h00)
        else $error("empty write mask");

    // data bits only where the mask writes
    a_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] & ~m_axis_tdata[15:8]) == 8'h00)
        else $error("data bit outside write mask");

    // a byte that is not the last one is filled through its LSB
    a_full_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[8])
        else $error("non-final byte not filled to its end");

endmodule

bind bit_field_copy_realigner bfcr_props u_bfcr_props (.*);
